// File: sv/hic_pkg.sv
package hic_pkg;

    // default sizes
    localparam int KEY_STORE_DEPTH_DEF = 127;
    localparam int ROW_COUNT_DEF       = 64;
    localparam int MAX_WAY_COUNT_DEF   = 4;
    localparam int MATE_WIDTH_DEF      = 32;

    // way byte layout
    localparam logic [7:0] OVF_MARK = 8'h80;
    localparam logic [6:0] IDX_MASK = 7'h7f;
    localparam int HASH_SHIFT_A = 7;
    localparam int HASH_SHIFT_B = 14;
    localparam int BLOCKED_BIT  = 63;
    localparam int MAX_LOG2     = 6;

    // register indexes
    localparam logic REG_BUCKET_LOG2 = 1'b0;
    localparam logic REG_WAY_COUNT   = 1'b1;

    typedef enum logic [1:0] {
        CMD_FIND   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        OC_MISS       = 3'd0,
        OC_HIT        = 3'd1,
        OC_BKT_MISS   = 3'd2,
        OC_FB_HIT     = 3'd3,
        OC_OVF_MISS   = 3'd4,
        OC_INSERTED   = 3'd5,
        OC_FULL       = 3'd6,
        OC_CLEARED    = 3'd7
    } outcome_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_WAY,
        ST_WCMP,
        ST_SCAN,
        ST_SCMP
    } state_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] key_mate;
        logic        key_blocked;
    } req_t;

    typedef struct packed {
        logic       found;
        logic [6:0] entry_index;
        logic [2:0] outcome;
        logic [6:0] compare_count;
        logic       stale_error;
    } res_t;

    // x ^= x >> 7; x ^= x >> 14; low six bits only
    function automatic logic [5:0] key_hash(input logic [31:0] mate, input logic blocked);
        logic [63:0] x;
        x = {32'd0, mate};
        x[BLOCKED_BIT] = blocked;
        x = x ^ (x >> HASH_SHIFT_A);
        x = x ^ (x >> HASH_SHIFT_B);
        return x[5:0];
    endfunction

endpackage

// File: sv/hashed_index_cache_with_fallback.sv
// Hashed recent-index cache over a key table of up to 127 keys. Raise start
// with a request while busy is low; one result follows on res with a one-cycle
// done strobe, which cannot be held off. Clear, full, unused commands and finds
// of an empty bucket are answered straight from the idle state. Insert reads the
// bucket row, then writes it back. A find of an occupied bucket reads the row,
// then compares the cached ways one by one, skipping stale ways; when the ways
// give no hit and the overflow mark is set, it scans the stored keys from the
// newest down, skipping keys the bucket holds, until a hit or the table's end.
// The key memory has a single read port and is read one key at a time.
module hashed_index_cache_with_fallback #(
    parameter int KEY_STORE_DEPTH = hic_pkg::KEY_STORE_DEPTH_DEF,
    parameter int ROW_COUNT       = hic_pkg::ROW_COUNT_DEF,
    parameter int MAX_WAY_COUNT   = hic_pkg::MAX_WAY_COUNT_DEF,
    parameter int MATE_WIDTH      = hic_pkg::MATE_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  hic_pkg::req_t req,
    output logic          done,
    output hic_pkg::res_t res,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int KS_AW  = (KEY_STORE_DEPTH > 1) ? $clog2(KEY_STORE_DEPTH) : 1;
    localparam int ROW_AW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int ROW_W  = 8 * MAX_WAY_COUNT;
    localparam int WAY_W  = $clog2(MAX_WAY_COUNT + 1);
    localparam int WIX    = (MAX_WAY_COUNT > 1) ? $clog2(MAX_WAY_COUNT) : 1;
    localparam logic [6:0] DEPTH7 = 7'(KEY_STORE_DEPTH);
    localparam logic [31:0] MATE_MASK =
        32'((64'd1 << MATE_WIDTH) - 64'd1);

    // memories
    logic [32:0]      key_mem [KEY_STORE_DEPTH];
    logic [ROW_W-1:0] row_mem [ROW_COUNT];
    logic [32:0]      key_q;
    logic [ROW_W-1:0] row_q;
    logic             key_we;
    logic [KS_AW-1:0] key_wa, key_ra;
    logic             row_we;
    logic [ROW_W-1:0] row_wd;
    logic [ROW_AW-1:0] row_ra;

    // control and datapath registers
    hic_pkg::state_t   state_reg, state_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [32:0]       key_reg, key_next;
    logic [ROW_AW-1:0] bkt_reg, bkt_next;
    logic              was_occ_reg, was_occ_next;
    logic [WAY_W-1:0]  way_reg, way_next;
    logic [6:0]        scan_reg, scan_next;
    logic [6:0]        cmp_reg, cmp_next;
    logic              stale_reg, stale_next;
    logic [6:0]        count_reg, count_next;
    logic [ROW_COUNT-1:0] occ_reg, occ_next;
    logic [2:0]        bl_reg, wc_reg;
    hic_pkg::res_t     res_reg, res_next;
    logic              done_reg, done_next;

    // bucket wrap table
    logic [ROW_AW-1:0] wrap_tab [64];
    for (genvar g = 0; g < 64; g++)
    begin : g_wrap
        assign wrap_tab[g] = ROW_AW'(g % ROW_COUNT);
    end

    // bucket of the incoming key
    logic [31:0]       mate_in;
    logic [5:0]        hash_in;
    logic [2:0]        lg;
    logic [ROW_AW-1:0] bkt_in;
    assign mate_in = req.key_mate & MATE_MASK;
    assign lg      = (bl_reg > 3'(hic_pkg::MAX_LOG2)) ? 3'(hic_pkg::MAX_LOG2) : bl_reg;
    assign hash_in = hic_pkg::key_hash(mate_in, req.key_blocked) & 6'((7'd1 << lg) - 7'd1);
    assign bkt_in  = wrap_tab[hash_in];

    // ways in use
    logic [WAY_W-1:0] ways;
    always_comb
    begin
        if (wc_reg == 3'd0)
            ways = WAY_W'(1);
        else if (32'(wc_reg) > MAX_WAY_COUNT)
            ways = WAY_W'(MAX_WAY_COUNT);
        else
            ways = WAY_W'(wc_reg);
    end

    // current way, its key index and key match
    logic [6:0] way_idx;
    logic [6:0] way_c;
    logic       key_match;
    assign way_idx   = row_q[8*way_reg[WIX-1:0] +: 7];
    assign way_c     = way_idx - 7'd1;
    assign key_match = (key_q == key_reg);

    // is scan index held by the bucket (stops at first empty way)
    logic [6:0] scan_i;
    logic       held;
    assign scan_i = scan_reg - 7'd1;
    always_comb
    begin
        logic stop;
        stop = 1'b0;
        held = 1'b0;
        for (int w = 0; w < MAX_WAY_COUNT; w++)
        begin
            if (!stop && WAY_W'(w) < ways)
            begin
                if (row_q[8*w +: 7] == 7'd0)
                    stop = 1'b1;
                else if (row_q[8*w +: 7] - 7'd1 == scan_i)
                    held = 1'b1;
            end
        end
    end

    // row after an insert
    logic [ROW_W-1:0] row_ins;
    always_comb
    begin
        logic ovf;
        ovf = row_q[7] | (row_q[8*(ways-WAY_W'(1)) +: 7] != 7'd0);
        row_ins = row_q;
        for (int w = 1; w < MAX_WAY_COUNT; w++)
        begin
            if (WAY_W'(w) < ways)
                row_ins[8*w +: 8] = was_occ_reg ? {1'b0, row_q[8*(w-1) +: 7]} : 8'd0;
        end
        row_ins[7:0] = {was_occ_reg & ovf, count_reg};
    end

    // next state and datapath
    always_comb
    begin
        hic_pkg::res_t r;
        r            = '0;
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        key_next     = key_reg;
        bkt_next     = bkt_reg;
        was_occ_next = was_occ_reg;
        way_next     = way_reg;
        scan_next    = scan_reg;
        cmp_next     = cmp_reg;
        stale_next   = stale_reg;
        count_next   = count_reg;
        occ_next     = occ_reg;
        res_next     = res_reg;
        done_next    = 1'b0;
        key_we       = 1'b0;
        key_wa       = count_reg[KS_AW-1:0];
        key_ra       = scan_i[KS_AW-1:0];
        row_we       = 1'b0;
        row_wd       = row_ins;
        row_ra       = (state_reg == hic_pkg::ST_IDLE) ? bkt_in : bkt_reg;
        case (state_reg)
            hic_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next     = req.cmd;
                    key_next     = {req.key_blocked, mate_in};
                    bkt_next     = bkt_in;
                    was_occ_next = occ_reg[bkt_in];
                    way_next     = '0;
                    cmp_next     = '0;
                    stale_next   = 1'b0;
                    case (hic_pkg::cmd_t'(req.cmd))
                        hic_pkg::CMD_FIND:
                        begin
                            if (!occ_reg[bkt_in])
                            begin
                                r.outcome = hic_pkg::OC_MISS;
                                res_next  = r;
                                done_next = 1'b1;
                            end
                            else
                                state_next = hic_pkg::ST_ROW;
                        end
                        hic_pkg::CMD_INSERT:
                        begin
                            if (count_reg == DEPTH7)
                            begin
                                r.outcome = hic_pkg::OC_FULL;
                                res_next  = r;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                key_we           = 1'b1;
                                count_next       = count_reg + 7'd1;
                                occ_next[bkt_in] = 1'b1;
                                state_next       = hic_pkg::ST_ROW;
                            end
                        end
                        hic_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                            occ_next   = '0;
                            r.outcome  = hic_pkg::OC_CLEARED;
                            res_next   = r;
                            done_next  = 1'b1;
                        end
                        default:
                        begin
                            res_next  = r;
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            hic_pkg::ST_ROW:
            begin
                if (cmd_reg == hic_pkg::CMD_INSERT)
                begin
                    row_we        = 1'b1;
                    r.entry_index = count_reg - 7'd1;
                    r.outcome     = hic_pkg::OC_INSERTED;
                    res_next      = r;
                    done_next     = 1'b1;
                    state_next    = hic_pkg::ST_IDLE;
                end
                else
                    state_next = hic_pkg::ST_WAY;
            end
            hic_pkg::ST_WAY:
            begin
                if (way_reg >= ways || way_idx == 7'd0)
                begin
                    if (!row_q[7])
                    begin
                        r.outcome       = hic_pkg::OC_BKT_MISS;
                        r.compare_count = cmp_reg;
                        r.stale_error   = stale_reg;
                        res_next        = r;
                        done_next       = 1'b1;
                        state_next      = hic_pkg::ST_IDLE;
                    end
                    else
                    begin
                        scan_next  = count_reg;
                        state_next = hic_pkg::ST_SCAN;
                    end
                end
                else if (way_c >= count_reg)
                begin
                    stale_next = 1'b1;
                    way_next   = way_reg + WAY_W'(1);
                end
                else
                begin
                    key_ra     = way_c[KS_AW-1:0];
                    state_next = hic_pkg::ST_WCMP;
                end
            end
            hic_pkg::ST_WCMP:
            begin
                cmp_next = (cmp_reg == 7'h7f) ? cmp_reg : cmp_reg + 7'd1;
                if (key_match)
                begin
                    r.found         = 1'b1;
                    r.entry_index   = way_c;
                    r.outcome       = hic_pkg::OC_HIT;
                    r.compare_count = cmp_next;
                    r.stale_error   = stale_reg;
                    res_next        = r;
                    done_next       = 1'b1;
                    state_next      = hic_pkg::ST_IDLE;
                end
                else
                begin
                    way_next   = way_reg + WAY_W'(1);
                    state_next = hic_pkg::ST_WAY;
                end
            end
            hic_pkg::ST_SCAN:
            begin
                if (scan_reg == 7'd0)
                begin
                    r.outcome       = hic_pkg::OC_OVF_MISS;
                    r.compare_count = cmp_reg;
                    r.stale_error   = stale_reg;
                    res_next        = r;
                    done_next       = 1'b1;
                    state_next      = hic_pkg::ST_IDLE;
                end
                else
                begin
                    scan_next = scan_i;
                    if (!held)
                        state_next = hic_pkg::ST_SCMP;
                end
            end
            hic_pkg::ST_SCMP:
            begin
                cmp_next = (cmp_reg == 7'h7f) ? cmp_reg : cmp_reg + 7'd1;
                if (key_match)
                begin
                    r.found         = 1'b1;
                    r.entry_index   = scan_reg;
                    r.outcome       = hic_pkg::OC_FB_HIT;
                    r.compare_count = cmp_next;
                    r.stale_error   = stale_reg;
                    res_next        = r;
                    done_next       = 1'b1;
                    state_next      = hic_pkg::ST_IDLE;
                end
                else
                    state_next = hic_pkg::ST_SCAN;
            end
            default:
                state_next = hic_pkg::ST_IDLE;
        endcase
    end

    // memories: one write, one registered read each
    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[key_wa] <= key_next;
        key_q <= key_mem[key_ra];
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
            row_mem[bkt_reg] <= row_wd;
        row_q <= row_mem[row_ra];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hic_pkg::ST_IDLE;
            count_reg <= '0;
            occ_reg   <= '0;
            done_reg  <= 1'b0;
            bl_reg    <= 3'd6;
            wc_reg    <= 3'd1;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            occ_reg   <= occ_next;
            done_reg  <= done_next;
            if (psel && penable && pwrite)
            begin
                if (paddr[2] == hic_pkg::REG_BUCKET_LOG2)
                    bl_reg <= pwdata[2:0];
                else
                    wc_reg <= pwdata[2:0];
            end
        end
    end

    // request payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        bkt_reg     <= bkt_next;
        was_occ_reg <= was_occ_next;
        way_reg     <= way_next;
        scan_reg    <= scan_next;
        cmp_reg     <= cmp_next;
        stale_reg   <= stale_next;
        res_reg     <= res_next;
    end

    assign busy   = (state_reg != hic_pkg::ST_IDLE);
    assign done   = done_reg;
    assign res    = res_reg;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == hic_pkg::REG_BUCKET_LOG2) ? {29'd0, bl_reg} : {29'd0, wc_reg};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH7)
        else $error("entry count beyond key store depth");

    a_found_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (res_reg.found == (res_reg.outcome == hic_pkg::OC_HIT
                                        || res_reg.outcome == hic_pkg::OC_FB_HIT)))
        else $error("found flag disagrees with outcome");

    a_no_cmp_outside_find: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (res_reg.outcome == hic_pkg::OC_INSERTED
                     || res_reg.outcome == hic_pkg::OC_FULL
                     || res_reg.outcome == hic_pkg::OC_CLEARED)
        |-> (res_reg.compare_count == 7'd0))
        else $error("comparisons reported for a non-find request");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && res_reg.outcome == hic_pkg::OC_INSERTED
        |-> (res_reg.entry_index == count_reg - 7'd1))
        else $error("inserted index does not match entry count");
`endif

endmodule

// File: dv/tb.sv
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Scoreboard: own copy of the key table and bucket rows, queue of expected results
    class cache_scoreboard;
        bit [32:0]       keys [127];
        int unsigned     entries;
        bit [7:0]        rows [64][4];
        bit [63:0]       occupied;
        bit [2:0]        log2_reg;
        bit [2:0]        ways_reg;
        hic_pkg::res_t   pending [$];
        int              errors;
        int              mismatches;
        int              finds;
        int              inserts;
        int              fb_hit_count;
        int              stale_seen;

        function void reset_state();
            entries  = 0;
            occupied = '0;
            log2_reg = 3'd6;
            ways_reg = 3'd1;
            foreach (rows[i, j]) rows[i][j] = '0;
        endfunction

        function void set_reg(bit idx, bit [2:0] value);
            if (idx == hic_pkg::REG_BUCKET_LOG2) log2_reg = value;
            else ways_reg = value;
        endfunction

        function int unsigned ways_in_use();
            if (ways_reg == 3'd0) return 1;
            if (ways_reg > 3'd4) return 4;
            return ways_reg;
        endfunction

        function int unsigned bucket_of(bit [31:0] mate, bit blk);
            bit [63:0]   x;
            int unsigned lg;
            x = {blk, 31'd0, mate};
            x = x ^ (x >> 7);
            x = x ^ (x >> 14);
            lg = (log2_reg > 3'd6) ? 6 : log2_reg;
            x = x & ((64'd1 << lg) - 64'd1);
            return int'(x[5:0]);
        endfunction

        function bit held_in_row(int unsigned b, int unsigned ways, int unsigned idx);
            int unsigned v;
            for (int w = 0; w < ways; w++)
            begin
                v = rows[b][w][6:0];
                if (v == 0) break;
                if (v - 1 == idx) return 1'b1;
            end
            return 1'b0;
        endfunction

        // work out the result of an accepted request and update the state
        function void note_request(hic_pkg::req_t r);
            hic_pkg::res_t e;
            int unsigned   ways, b, v, c, cmp, i;
            bit            fin, ovf;
            e = '0;
            ways = ways_in_use();
            cmp = 0;
            case (hic_pkg::cmd_t'(r.cmd))
                hic_pkg::CMD_FIND:
                begin
                    finds++;
                    b = bucket_of(r.key_mate, r.key_blocked);
                    fin = 1'b0;
                    if (!occupied[b])
                    begin
                        e.outcome = hic_pkg::OC_MISS;
                        fin = 1'b1;
                    end
                    if (!fin)
                    begin
                        ovf = rows[b][0][7];
                        for (int w = 0; w < ways && !fin; w++)
                        begin
                            v = rows[b][w][6:0];
                            if (v == 0) break;
                            c = v - 1;
                            if (c >= entries || c >= 127)
                            begin
                                e.stale_error = 1'b1;
                                continue;
                            end
                            cmp++;
                            if (keys[c] == {r.key_blocked, r.key_mate})
                            begin
                                e.found = 1'b1;
                                e.entry_index = 7'(c);
                                e.outcome = hic_pkg::OC_HIT;
                                fin = 1'b1;
                            end
                        end
                        if (!fin && !ovf)
                        begin
                            e.outcome = hic_pkg::OC_BKT_MISS;
                            fin = 1'b1;
                        end
                        if (!fin)
                        begin
                            e.outcome = hic_pkg::OC_OVF_MISS;
                            i = entries;
                            while (i > 0)
                            begin
                                i--;
                                if (held_in_row(b, ways, i)) continue;
                                cmp++;
                                if (keys[i] == {r.key_blocked, r.key_mate})
                                begin
                                    e.found = 1'b1;
                                    e.entry_index = 7'(i);
                                    e.outcome = hic_pkg::OC_FB_HIT;
                                    break;
                                end
                            end
                        end
                    end
                    e.compare_count = (cmp > 127) ? 7'd127 : 7'(cmp);
                    if (e.outcome == hic_pkg::OC_FB_HIT) fb_hit_count++;
                    if (e.stale_error) stale_seen++;
                end
                hic_pkg::CMD_INSERT:
                begin
                    inserts++;
                    if (entries >= 127)
                        e.outcome = hic_pkg::OC_FULL;
                    else
                    begin
                        b = bucket_of(r.key_mate, r.key_blocked);
                        keys[entries] = {r.key_blocked, r.key_mate};
                        if (!occupied[b])
                        begin
                            rows[b][0] = 8'(entries + 1);
                            for (int w = 1; w < ways; w++) rows[b][w] = '0;
                            occupied[b] = 1'b1;
                        end
                        else
                        begin
                            ovf = rows[b][0][7] || (rows[b][ways-1][6:0] != 0);
                            for (int w = ways - 1; w > 0; w--)
                                rows[b][w] = {1'b0, rows[b][w-1][6:0]};
                            rows[b][0] = {ovf, 7'(entries + 1)};
                        end
                        e.entry_index = 7'(entries);
                        e.outcome = hic_pkg::OC_INSERTED;
                        entries++;
                    end
                end
                hic_pkg::CMD_CLEAR:
                begin
                    entries  = 0;
                    occupied = '0;
                    e.outcome = hic_pkg::OC_CLEARED;
                end
                default: ;
            endcase
            pending = {pending, e};
        endfunction

        function void check_result(hic_pkg::res_t got);
            hic_pkg::res_t e;
            if (pending.size() == 0)
            begin
                errors++;
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e)
            begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: found %0b/%0b idx %0d/%0d outcome %0d/%0d ",
                              "cmp %0d/%0d stale %0b/%0b (exp/got)"},
                             e.found, got.found, e.entry_index, got.entry_index,
                             e.outcome, got.outcome, e.compare_count, got.compare_count,
                             e.stale_error, got.stale_error);
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    hic_pkg::req_t req;
    logic          done;
    hic_pkg::res_t res;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    cache_scoreboard sb;
    int              sent;
    bit              no_gaps;
    hic_pkg::req_t   pool [6];

    hashed_index_cache_with_fallback DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .res     (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done) sb.check_result(res);
    end

    // overall time limit
    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    // present one request, hold until accepted, then unless no_gaps drop start for a random idle gap
    task automatic send(input hic_pkg::cmd_t c, input logic [31:0] mate, input logic blk);
        int gap;
        @(negedge clk);
        start <= 1'b1;
        req   <= '{cmd: c, key_mate: mate, key_blocked: blk};
        forever
        begin
            @(posedge clk);
            if (!busy) break;
        end
        sb.note_request('{cmd: c, key_mate: mate, key_blocked: blk});
        sent++;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // stop sending and wait until every expected result is in
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [2:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {$urandom() & 32'hffff_fff8} | value;
        @(negedge clk);
        penable <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (pready) break;
        end
        sb.set_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic pool_request(input int pct_insert);
        int            r;
        hic_pkg::req_t k;
        r = $urandom_range(0, 99);
        k = pool[$urandom_range(0, 5)];
        if ($urandom_range(0, 3) == 0)
        begin
            k.key_mate    = $urandom();
            k.key_blocked = $urandom_range(0, 1);
        end
        if (r < pct_insert)  send(hic_pkg::CMD_INSERT, k.key_mate, k.key_blocked);
        else if (r < 92)     send(hic_pkg::CMD_FIND, k.key_mate, k.key_blocked);
        else if (r < 96)     send(hic_pkg::CMD_CLEAR, $urandom(), $urandom_range(0, 1));
        else                 send(hic_pkg::CMD_NONE, $urandom(), $urandom_range(0, 1));
    endtask

    initial
    begin
        bit [2:0] lg_pick, way_pick;
        int       phase;
        sb = new();
        sb.reset_state();
        start   = 1'b0;
        req     = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        rst_n   = 1'b0;
        sent    = 0;
        no_gaps = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: one bucket, four ways
        write_reg(hic_pkg::REG_BUCKET_LOG2, 3'd0);
        write_reg(hic_pkg::REG_WAY_COUNT, 3'd4);
        send(hic_pkg::CMD_FIND, 32'hffff_ffff, 1'b1);
        send(hic_pkg::CMD_INSERT, 32'hffff_ffff, 1'b1);
        send(hic_pkg::CMD_INSERT, 32'h0000_0000, 1'b0);
        send(hic_pkg::CMD_FIND, 32'hffff_ffff, 1'b1);
        send(hic_pkg::CMD_FIND, 32'h0000_0000, 1'b1);
        send(hic_pkg::CMD_NONE, 32'h1234_5678, 1'b1);
        send(hic_pkg::CMD_INSERT, 32'h5555_5555, 1'b0);
        send(hic_pkg::CMD_INSERT, 32'haaaa_aaaa, 1'b1);
        send(hic_pkg::CMD_INSERT, 32'h8000_0001, 1'b0);
        // oldest key has fallen out of the ways: fallback scan
        send(hic_pkg::CMD_FIND, 32'hffff_ffff, 1'b1);
        send(hic_pkg::CMD_FIND, 32'hdead_beef, 1'b0);
        send(hic_pkg::CMD_FIND, 32'h8000_0001, 1'b0);
        send(hic_pkg::CMD_CLEAR, 32'h0, 1'b0);
        drain();
        // stale ways: shrink ways, reoccupy, widen again over the older row contents
        write_reg(hic_pkg::REG_WAY_COUNT, 3'd1);
        send(hic_pkg::CMD_INSERT, 32'h0000_0042, 1'b0);
        drain();
        write_reg(hic_pkg::REG_WAY_COUNT, 3'd4);
        send(hic_pkg::CMD_FIND, 32'h0000_0099, 1'b1);
        send(hic_pkg::CMD_FIND, 32'h0000_0042, 1'b0);
        send(hic_pkg::CMD_CLEAR, 32'h0, 1'b0);
        drain();

        // random phases, each starting from a cleared table
        phase = 0;
        while (sent < 600)
        begin
            case (phase)
                0: begin lg_pick = 3'd6; way_pick = 3'd1; end
                1: begin lg_pick = 3'd7; way_pick = 3'd0; end
                2: begin lg_pick = 3'd0; way_pick = 3'd4; end
                3: begin lg_pick = 3'd1; way_pick = 3'd7; end
                default:
                begin
                    lg_pick  = $urandom_range(0, 7);
                    way_pick = $urandom_range(0, 7);
                end
            endcase
            write_reg(hic_pkg::REG_BUCKET_LOG2, lg_pick);
            write_reg(hic_pkg::REG_WAY_COUNT, way_pick);
            no_gaps = ($urandom_range(0, 3) == 0);
            foreach (pool[i])
            begin
                pool[i].key_mate    = $urandom();
                pool[i].key_blocked = $urandom_range(0, 1);
            end
            if (phase % 4 == 2)
            begin
                // fill the table past capacity, then long scans
                for (int n = 0; n < 130; n++)
                    send(hic_pkg::CMD_INSERT,
                         (n % 5 == 0) ? pool[n % 6].key_mate : $urandom(),
                         $urandom_range(0, 1));
                repeat (12) pool_request(10);
            end
            else
            begin
                repeat (60) pool_request(45);
            end
            drain();
            send(hic_pkg::CMD_CLEAR, $urandom(), $urandom_range(0, 1));
            drain();
            phase++;
        end

        drain();
        repeat (300) @(posedge clk);
        $display("tb: %0d requests, %0d finds, %0d inserts, %0d fallback hits, %0d stale finds",
                 sent, sb.finds, sb.inserts, sb.fb_hit_count, sb.stale_seen);
        $display("tb: %0d phases over bucket and way settings, %0d mismatches",
                 phase, sb.mismatches);
        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
